[hdl/u2c_pkg.sv]
// Package for the UTF-8 to CESU-8 transcoder: constants and shared types.
`timescale 1ns / 1ps
`default_nettype none

package u2c_pkg;

  // Largest number of output bytes one input byte can cause
  localparam int unsigned RunMax = 6;
  localparam int unsigned CntW   = 3;

  // Replacement character EF BF BD
  localparam logic [7:0] RepByte0 = 8'hEF;
  localparam logic [7:0] RepByte1 = 8'hBF;
  localparam logic [7:0] RepByte2 = 8'hBD;

  // Surrogate pair lead and marker bytes
  localparam logic [7:0] SurLead    = 8'hED;
  localparam logic [3:0] SurHighTag = 4'hA;
  localparam logic [3:0] SurLowTag  = 4'hB;

  // Code point range limits
  localparam logic [20:0] TwoByteMax   = 21'h0007FF;
  localparam logic [20:0] ThreeByteMax = 21'h00FFFF;

  // Sequence state kept between input bytes
  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] accum;
  } seq_state_t;

  // Output bytes caused by one input byte, first byte in slot 0
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
  } run_t;

endpackage : u2c_pkg

`default_nettype wire

[hdl/u2c_decode.sv]
// Decode of one UTF-8 byte against the sequence state into a CESU-8 byte run.
`timescale 1ns / 1ps
`default_nettype none

module u2c_decode (
  input  u2c_pkg::seq_state_t state_i,
  input  logic [7:0]          byte_in_i,
  input  logic                end_of_text_i,
  output u2c_pkg::seq_state_t state_o,
  output u2c_pkg::run_t       run_o
);
  import u2c_pkg::*;

  logic        is_cont;
  logic        continue_seq;
  logic        broken;
  logic [20:0] cp;
  logic [1:0]  pend_dec;
  logic [3:0]  plane_m1;
  logic [2:0][7:0] fresh_bytes;
  logic [1:0]  fresh_cnt;
  seq_state_t  fresh_state;
  run_t        cp_run;

  assign is_cont      = (byte_in_i[7:6] == 2'b10);
  assign continue_seq = (state_i.pending != 2'd0) && is_cont;
  assign broken       = (state_i.pending != 2'd0) && !is_cont;
  assign cp           = {state_i.accum[14:0], byte_in_i[5:0]};
  assign pend_dec     = state_i.pending - 2'd1;
  assign plane_m1     = cp[19:16] - 4'd1;

  // Re-encode the completed code point
  always_comb begin
    cp_run.bytes = '0;
    if (cp <= TwoByteMax) begin
      cp_run.bytes[0] = {3'b110, cp[10:6]};
      cp_run.bytes[1] = {2'b10, cp[5:0]};
      cp_run.count    = CntW'(2);
    end else if (cp <= ThreeByteMax) begin
      cp_run.bytes[0] = {4'b1110, cp[15:12]};
      cp_run.bytes[1] = {2'b10, cp[11:6]};
      cp_run.bytes[2] = {2'b10, cp[5:0]};
      cp_run.count    = CntW'(3);
    end else begin
      cp_run.bytes[0] = SurLead;
      cp_run.bytes[1] = {SurHighTag, plane_m1};
      cp_run.bytes[2] = {2'b10, cp[15:10]};
      cp_run.bytes[3] = SurLead;
      cp_run.bytes[4] = {SurLowTag, cp[9:6]};
      cp_run.bytes[5] = {2'b10, cp[5:0]};
      cp_run.count    = CntW'(6);
    end
  end

  // Byte taken as a fresh start: ASCII, lead byte or invalid
  always_comb begin
    fresh_bytes = '0;
    fresh_cnt   = 2'd0;
    fresh_state = state_i;
    priority if (!byte_in_i[7]) begin
      fresh_bytes[0]      = byte_in_i;
      fresh_cnt           = 2'd1;
      fresh_state.pending = 2'd0;
    end else if (byte_in_i[7:5] == 3'b110) begin
      fresh_state.accum   = {16'd0, byte_in_i[4:0]};
      fresh_state.pending = 2'd1;
    end else if (byte_in_i[7:4] == 4'b1110) begin
      fresh_state.accum   = {17'd0, byte_in_i[3:0]};
      fresh_state.pending = 2'd2;
    end else if (byte_in_i[7:3] == 5'b11110) begin
      fresh_state.accum   = {18'd0, byte_in_i[2:0]};
      fresh_state.pending = 2'd3;
    end else begin
      fresh_bytes         = {RepByte2, RepByte1, RepByte0};
      fresh_cnt           = 2'd3;
      fresh_state.pending = 2'd0;
    end
  end

  // Merge the paths; end of text drops any partial sequence
  always_comb begin
    run_o   = '0;
    state_o = fresh_state;
    if (continue_seq) begin
      state_o.accum   = cp;
      state_o.pending = pend_dec;
      if (pend_dec == 2'd0) begin
        run_o = cp_run;
      end
    end else if (broken) begin
      run_o.bytes[0] = RepByte0;
      run_o.bytes[1] = RepByte1;
      run_o.bytes[2] = RepByte2;
      run_o.bytes[3] = fresh_bytes[0];
      run_o.bytes[4] = fresh_bytes[1];
      run_o.bytes[5] = fresh_bytes[2];
      run_o.count    = CntW'(3) + CntW'(fresh_cnt);
    end else begin
      run_o.bytes[0] = fresh_bytes[0];
      run_o.bytes[1] = fresh_bytes[1];
      run_o.bytes[2] = fresh_bytes[2];
      run_o.count    = CntW'(fresh_cnt);
    end
    if (end_of_text_i) begin
      state_o = '0;
    end
  end

endmodule : u2c_decode

`default_nettype wire

[hdl/utf8_to_cesu8_transcoder.sv]
// Top level of the UTF-8 to CESU-8 transcoder: sequence state and output run buffer.
//
// Input channel: one UTF-8 byte per transfer (byte_in_i, end_of_text_i) on
// in_valid_i / in_ready_o. Output channel: one CESU-8 byte per transfer
// (byte_out_o, run_last_o) on out_valid_o / out_ready_i; run_last_o marks the
// last byte caused by one input byte. An input byte that completes nothing
// causes no output transfer.
// The first output byte of an input byte is offered the cycle after its transfer.
// An input byte that causes at most one output byte is taken every cycle while the
// receiver does not stall; one that causes several holds the run buffer until all
// have left, as the output port moves one byte a cycle when the receiver takes it.
// A new byte is taken in the same cycle as the last byte of the previous run leaves.
// Reset clears the sequence state and empties the run buffer.
// When the receiver stalls, the run buffer holds its bytes and in_ready_o
// stays low until the cycle in which the last byte of the run is taken.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_cesu8_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       run_last_o
);
  import u2c_pkg::*;

  seq_state_t state_q, state_d, dec_state;
  run_t       dec_run;
  logic [RunMax-1:0][7:0] run_q, run_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic in_xfer, out_xfer;

  u2c_decode u_decode (
    .state_i       (state_q),
    .byte_in_i     (byte_in_i),
    .end_of_text_i (end_of_text_i),
    .state_o       (dec_state),
    .run_o         (dec_run)
  );

  // Handshakes
  assign out_valid_o = (cnt_q != '0);
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign byte_out_o  = run_q[0];
  assign run_last_o  = (cnt_q == CntW'(1));

  // Next state of sequence and run buffer
  always_comb begin
    state_d = state_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    if (out_xfer) begin
      run_d = run_q >> 8;
      cnt_d = cnt_q - CntW'(1);
    end
    if (in_xfer) begin
      state_d = dec_state;
      run_d   = dec_run.bytes;
      cnt_d   = dec_run.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Run bytes carry no reset
  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  // The run buffer never holds more than one full run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RunMax))
    else $error("run buffer count out of range");

  // A new byte is never taken while earlier output bytes would remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > CntW'(1)) |-> !in_ready_o)
    else $error("input taken while run still pending");

  // A stalled output run keeps its count when no input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (cnt_q == $past(cnt_q)))
    else $error("run count changed during output stall");

  // Taking a byte from a run of several leaves one fewer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && (cnt_q > CntW'(1))) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("run count did not step down");

endmodule : utf8_to_cesu8_transcoder

`default_nettype wire

[tb/sv/utf8_to_cesu8_transcoder_tb.sv]
// Self-checking testbench for the UTF-8 to CESU-8 transcoder.
`timescale 1ns / 1ps

module utf8_to_cesu8_transcoder_tb;
  import u2c_pkg::*;

  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned MaxGap       = 10;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned ExpDepth     = 64;

  // One expected output byte and its end-of-run flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cesu_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] byte_in_i     = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] byte_out_o;
  logic       run_last_o;

  // Shadow sequence state
  logic [1:0]  seq_pending;
  logic [20:0] seq_accum;

  // Bytes of the run being predicted
  logic [7:0]  run_bytes [RunMax];
  int unsigned run_len = 0;

  // Expected output bytes, in order
  cesu_byte_t  exp_ring [ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  cesu_byte_t  head_byte;

  int unsigned send_gap_max   = 0;
  int unsigned recv_stall_max = 0;
  int unsigned items_sent     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned full_runs      = 0;
  int unsigned eot_marks      = 0;
  int unsigned mismatch_count = 0;

  utf8_to_cesu8_transcoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_o    (byte_out_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Transcoding predictor
  // ---------------------------------------------------------------------------

  function void emit(input logic [7:0] b);
    run_bytes[run_len] = b;
    run_len++;
  endfunction

  function void emit_replacement();
    emit(RepByte0);
    emit(RepByte1);
    emit(RepByte2);
  endfunction

  // Re-encode a finished code point; above the BMP it becomes a surrogate pair
  function void emit_code_point(input logic [20:0] cp);
    logic [3:0] plane_m1;
    plane_m1 = cp[19:16] - 4'd1;
    if (cp <= TwoByteMax) begin
      emit({3'b110, cp[10:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp <= ThreeByteMax) begin
      emit({4'b1110, cp[15:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else begin
      emit(SurLead);
      emit({SurHighTag, plane_m1});
      emit({2'b10, cp[15:10]});
      emit(SurLead);
      emit({SurLowTag, cp[9:6]});
      emit({2'b10, cp[5:0]});
    end
  endfunction

  // Advance the shadow state by one input byte and queue the bytes it causes
  function void predict_run(input logic [7:0] c, input logic eot);
    logic taken;
    int   n;
    taken   = 1'b0;
    run_len = 0;

    // Continuation of an open sequence, or a break of it
    if (seq_pending != 2'd0) begin
      if (c[7:6] == 2'b10) begin
        seq_accum   = {seq_accum[14:0], c[5:0]};
        seq_pending = seq_pending - 2'd1;
        if (seq_pending == 2'd0) emit_code_point(seq_accum);
        taken = 1'b1;
      end else begin
        emit_replacement();
        seq_pending = 2'd0;
      end
    end

    // Fresh byte: ASCII, lead, stray continuation or invalid lead
    if (!taken) begin
      if (!c[7]) begin
        emit(c);
      end else if (c[7:5] == 3'b110) begin
        seq_accum   = {16'd0, c[4:0]};
        seq_pending = 2'd1;
      end else if (c[7:4] == 4'b1110) begin
        seq_accum   = {17'd0, c[3:0]};
        seq_pending = 2'd2;
      end else if (c[7:3] == 5'b11110) begin
        seq_accum   = {18'd0, c[2:0]};
        seq_pending = 2'd3;
      end else begin
        emit_replacement();
        seq_pending = 2'd0;
      end
    end

    if (eot) begin
      seq_pending = 2'd0;
      seq_accum   = 21'd0;
    end

    n = run_len;
    if (n == RunMax) full_runs++;
    for (int i = 0; i < n; i++) begin
      exp_ring[exp_wr % ExpDepth] = '{data: run_bytes[i], last: (i == n - 1)};
      exp_wr++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and output checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_checked++;
      if (exp_wr == exp_rd) begin
        flag_mismatch($sformatf("unexpected byte %02h last %0b", byte_out_o, run_last_o));
      end else begin
        head_byte = exp_ring[exp_rd % ExpDepth];
        exp_rd++;
        if (byte_out_o !== head_byte.data)
          flag_mismatch($sformatf("byte_out %02h, expected %02h", byte_out_o, head_byte.data));
        if (run_last_o !== head_byte.last)
          flag_mismatch($sformatf("run_last %0b, expected %0b on byte %02h",
                                  run_last_o, head_byte.last, head_byte.data));
      end
    end
  end

  // Receiver: random stall before taking each output byte
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one input byte after a random gap; returns at its transfer edge
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    byte_in_i     <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    predict_run(b, eot);
    items_sent++;
    if (eot) eot_marks++;
  endtask

  task automatic test_ascii_and_two_byte();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // overlong NUL stays C0 80
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_four_byte();
    // highest valid code point, then the largest four-byte value, beyond the Unicode range
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_malformed();
    // stray continuation, invalid lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // broken by ASCII
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    // broken by a new lead that then completes a three-byte char
    send_byte(8'hC3, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // broken by an invalid lead: two replacements from one byte
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hF8, 1'b0);
  endtask

  task automatic test_end_of_text();
    // partial sequence dropped, next continuation is stray
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hBF, 1'b0);
  endtask

  // Mostly well-formed characters with random payload, plus noise and cut sequences
  task automatic send_random_char();
    int unsigned kind;
    int unsigned n_cont;
    int unsigned n_send;
    logic [7:0]  lead;
    logic        end_mark;
    kind     = $urandom_range(0, 11);
    end_mark = ($urandom_range(0, 7) == 0);
    n_cont   = 0;
    case (kind)
      0, 1, 2: lead = {1'b0, 7'($urandom)};
      3, 4: begin
        lead   = {3'b110, 5'($urandom)};
        n_cont = 1;
      end
      5, 6: begin
        lead   = {4'b1110, 4'($urandom)};
        n_cont = 2;
      end
      7, 8: begin
        lead   = {5'b11110, 3'($urandom)};
        n_cont = 3;
      end
      9: lead = $urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
      10: begin
        lead   = $urandom_range(0, 1) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)};
        n_cont = 0;
      end
      default: lead = 8'($urandom);
    endcase
    n_send = 1 + n_cont;
    // cut sequence: lead plus fewer continuations than it asks for
    if (kind == 10) n_send = 1 + $urandom_range(0, lead[4] ? 2 : 1);
    if (n_send == 1) begin
      send_byte(lead, end_mark);
    end else begin
      send_byte(lead, 1'b0);
      for (int i = 1; i < n_send; i++) begin
        send_byte({2'b10, 6'($urandom)}, (i == n_send - 1) ? end_mark : 1'b0);
      end
    end
  endtask

  task automatic test_random_text(input int unsigned n_items, input int unsigned gap_max,
                                  input int unsigned stall_max);
    int unsigned stop_at;
    send_gap_max   = gap_max;
    recv_stall_max = stall_max;
    stop_at        = items_sent + n_items;
    while (items_sent < stop_at) send_random_char();
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    seq_pending = 2'd0;
    seq_accum   = 21'd0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_max   = MaxGap;
    recv_stall_max = MaxGap;
    test_ascii_and_two_byte();
    test_four_byte();
    test_malformed();
    test_end_of_text();

    test_random_text(110, MaxGap, MaxGap);
    test_random_text(50, 0, 0);
    test_random_text(45, 0, MaxGap);
    test_random_text(45, MaxGap, 0);
    wait_for_drain();

    $display("Covered %0d input bytes (%0d end-of-text marks), %0d output bytes checked,",
             items_sent, eot_marks, bytes_checked);
    $display("%0d six-byte runs, random and burst flow control on both sides.", full_runs);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
